// ===== rtl/core/mta_pkg.sv =====
// Package for the mosaic tile average unit.
// Holds field widths, register indexes, reset values and the controller state type.
// No dependencies.
`default_nettype none

package mta_pkg;

  localparam int DIM_W      = 12;
  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 8;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int SUM_W      = AREA_W + PIX_W;
  localparam int TILE_IDX_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV
  } mta_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mta_div_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mta_if.sv =====
// Stream interfaces of the mosaic tile average unit: pixel input and tile result output.
// Depends on mta_pkg for the field widths.
`default_nettype none

interface mta_pixel_if;
  import mta_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mta_tile_if;
  import mta_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TILE_IDX_W-1:0] tile_row;
  logic [TILE_IDX_W-1:0] tile_col;
  logic [MEAN_W-1:0]     mean;
  logic                  frame_done;
  modport source (output valid, output tile_row, output tile_col, output mean,
                  output frame_done, input ready);
  modport sink   (input valid, input tile_row, input tile_col, input mean,
                  input frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mta_step_calc.sv =====
// Tile step unit: divides frame width and height by the grid size.
// A constant reciprocal multiplication gives both quotients, which are registered on start. Depends on mta_pkg.
`default_nettype none

module mta_step_calc
  import mta_pkg::*;
#(
  parameter int GRID_COLS = 20,
  parameter int GRID_ROWS = 20
) (
  input  logic             clk,
  input  logic             start,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  output logic [DIM_W-1:0] step_x,
  output logic [DIM_W-1:0] step_y
);

  // The reciprocal is rounded up with twice the operand width of fraction, so the
  // truncated product equals the exact quotient for every operand value.
  localparam int RCP_SHIFT = 2 * DIM_W;
  localparam int RCP_W     = RCP_SHIFT + 1;
  localparam int PROD_W    = RCP_SHIFT + DIM_W;
  localparam logic [RCP_W-1:0] RCP_X =
    RCP_W'((longint'(1) << RCP_SHIFT) / longint'(GRID_COLS) + longint'(1));
  localparam logic [RCP_W-1:0] RCP_Y =
    RCP_W'((longint'(1) << RCP_SHIFT) / longint'(GRID_ROWS) + longint'(1));

  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;

  assign prod_x = PROD_W'(frame_width) * PROD_W'(RCP_X);
  assign prod_y = PROD_W'(frame_height) * PROD_W'(RCP_Y);

  always_ff @(posedge clk) begin
    if (start) begin
      step_x <= prod_x[RCP_SHIFT +: DIM_W];
      step_y <= prod_y[RCP_SHIFT +: DIM_W];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mta_mean_div.sv =====
// Mean divider: restoring division of a tile sum by its area, one quotient bit a cycle.
// The quotient of a mean never exceeds the pixel range. Depends on mta_pkg.
`default_nettype none

module mta_mean_div
  import mta_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  input  logic [AREA_W-1:0] area,
  output logic [MEAN_W-1:0] mean,
  output mta_div_status_t   status
);

  localparam int CNT_W = $clog2(MEAN_W);

  logic [SUM_W-1:0]  rem;
  logic [AREA_W-1:0] den;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  cand;
  logic              take;

  assign cand = {{(SUM_W-AREA_W){1'b0}}, den} << cnt;
  assign take = rem >= cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else if (start) begin
      status <= '{busy: 1'b1, done: 1'b0};
      cnt    <= CNT_W'(MEAN_W - 1);
    end else if (status.busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        status <= '{busy: 1'b0, done: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= sum;
      den  <= area;
      mean <= '0;
    end else if (status.busy) begin
      if (take) begin
        rem <= rem - cand;
      end
      mean <= {mean[MEAN_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mta_sum_mem.sv =====
// Tile sum memory: one running sum per grid column, with a synchronous registered read.
// Entries not written since reset or restart read as zero. Depends on mta_pkg.
`default_nettype none

module mta_sum_mem
  import mta_pkg::*;
#(
  parameter int DEPTH  = 20,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [SUM_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [SUM_W-1:0]  wr_data
);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [SUM_W-1:0] rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/mosaic_tile_average_unit.sv =====
// Mosaic tile average unit: splits a raster frame into a grid of tiles and emits tile means.
// Depends on mta_pkg, mta_if, mta_step_calc, mta_mean_div and mta_sum_mem.
//
// Usage:
//   pixels carries one 8-bit grayscale pixel per transfer in raster order. tiles carries
//   one result per finished tile: grid row, grid column, truncated mean and a flag on the
//   last tile of the frame. Both channels transfer when valid and ready are high together.
//   cfg_we with cfg_index and cfg_data writes frame_width (index 0) or frame_height
//   (index 1); a write restarts the frame and clears all sums. Writes to other indexes
//   are ignored.
// Sequence:
//   A pixel that does not finish a tile needs a read of its column's sum from the sum
//   memory and a write back of the updated sum. A pixel that finishes a tile needs the
//   read, a write back that clears the sum, the bit-serial mean divider on the sum and
//   the area product, and the load of the output register.
//   After reset and after each write to frame_width or frame_height, ready stays low
//   while the tile steps are loaded from a reciprocal multiplication.
// Stalls:
//   The output register holds a result until it is taken. Pixels keep being accepted;
//   only a tile completion that meets a still full output register waits for it.
`default_nettype none

module mosaic_tile_average_unit
  import mta_pkg::*;
#(
  parameter int GRID_COLS = 20,
  parameter int GRID_ROWS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mta_pixel_if.sink             pixels,
  mta_tile_if.source            tiles
);

  localparam int TC_W  = $clog2(GRID_COLS + 1);
  localparam int TR_W  = $clog2(GRID_ROWS + 1);
  localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

  mta_state_t state;
  mta_state_t state_next;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             calc_start;
  logic             restart;

  logic [DIM_W-1:0] step_x;
  logic [DIM_W-1:0] step_y;

  logic [DIM_W-1:0] col_count;
  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] ox;
  logic [DIM_W-1:0] oy;
  logic [TC_W-1:0]  tc;
  logic [TR_W-1:0]  tr;

  logic [DIM_W-1:0] span_x;
  logic [DIM_W-1:0] span_y;
  logic             in_x;
  logic             in_y;
  logic             end_x;
  logic             end_y;
  logic             last_x;
  logic             last_y;
  logic [DIM_W:0]   col_inc;
  logic [DIM_W:0]   row_inc;
  logic             accept;

  logic [PIX_W-1:0] pix_q;
  logic             hit_q;
  logic             end_q;
  logic             done_q;
  logic [TC_W-1:0]  col_q;
  logic [TR_W-1:0]  row_q;
  logic [DIM_W-1:0] w_q;
  logic [DIM_W-1:0] h_q;

  logic [SUM_W-1:0]  rd_data;
  logic [SUM_W-1:0]  sum;
  logic              mem_we;
  logic              div_start;
  logic [AREA_W-1:0] area;
  logic [MEAN_W-1:0] div_mean;
  mta_div_status_t   div_status;
  logic              out_free;
  logic              out_load;

  assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      calc_start   <= 1'b1;
    end else begin
      calc_start <= restart;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  mta_step_calc #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_step_calc (
    .clk          (clk),
    .start        (calc_start),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .step_x       (step_x),
    .step_y       (step_y)
  );

  assign span_x = (tc == TC_W'(GRID_COLS - 1)) ? step_x - DIM_W'(1) : step_x;
  assign span_y = (tr == TR_W'(GRID_ROWS - 1)) ? step_y - DIM_W'(1) : step_y;
  assign in_x   = (step_x != '0) && (tc < TC_W'(GRID_COLS)) && (ox < span_x);
  assign in_y   = (step_y != '0) && (tr < TR_W'(GRID_ROWS)) && (oy < span_y);
  assign end_x  = ox == span_x - DIM_W'(1);
  assign end_y  = oy == span_y - DIM_W'(1);

  assign last_x = (step_x >= DIM_W'(2) && tc == TC_W'(GRID_COLS - 1)) ||
                  (step_x == DIM_W'(1) && GRID_COLS >= 2 && int'(tc) == GRID_COLS - 2);
  assign last_y = (step_y >= DIM_W'(2) && tr == TR_W'(GRID_ROWS - 1)) ||
                  (step_y == DIM_W'(1) && GRID_ROWS >= 2 && int'(tr) == GRID_ROWS - 2);

  assign col_inc = {1'b0, col_count} + (DIM_W+1)'(1);
  assign row_inc = {1'b0, row_count} + (DIM_W+1)'(1);

  assign pixels.ready = (state == ST_IDLE) && !calc_start;
  assign accept       = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
      ox        <= '0;
      oy        <= '0;
      tc        <= '0;
      tr        <= '0;
    end else if (accept) begin
      if (col_inc >= {1'b0, frame_width}) begin
        col_count <= '0;
        ox        <= '0;
        tc        <= '0;
        if (row_inc >= {1'b0, frame_height}) begin
          row_count <= '0;
          oy        <= '0;
          tr        <= '0;
        end else begin
          row_count <= row_inc[DIM_W-1:0];
          if (tr < TR_W'(GRID_ROWS)) begin
            if ({1'b0, oy} + (DIM_W+1)'(1) == {1'b0, step_y}) begin
              oy <= '0;
              tr <= tr + TR_W'(1);
            end else begin
              oy <= oy + DIM_W'(1);
            end
          end
        end
      end else begin
        col_count <= col_inc[DIM_W-1:0];
        if (tc < TC_W'(GRID_COLS)) begin
          if ({1'b0, ox} + (DIM_W+1)'(1) == {1'b0, step_x}) begin
            ox <= '0;
            tc <= tc + TC_W'(1);
          end else begin
            ox <= ox + DIM_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q  <= pixels.pixel;
      hit_q  <= in_x && in_y;
      end_q  <= end_x && end_y;
      done_q <= last_x && last_y;
      col_q  <= tc;
      row_q  <= tr;
      w_q    <= span_x;
      h_q    <= span_y;
    end
  end

  mta_sum_mem #(
    .DEPTH  (GRID_COLS),
    .ADDR_W (COL_W)
  ) u_sum_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (restart),
    .rd_addr (tc[COL_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (col_q[COL_W-1:0]),
    .wr_data (end_q ? '0 : sum)
  );

  assign sum       = rd_data + SUM_W'(pix_q);
  assign mem_we    = (state == ST_ACC) && hit_q;
  assign div_start = (state == ST_ACC) && hit_q && end_q;
  assign area      = AREA_W'(w_q) * AREA_W'(h_q);

  mta_mean_div u_mean_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .sum    (sum),
    .area   (area),
    .mean   (div_mean),
    .status (div_status)
  );

  assign out_free = !tiles.valid || tiles.ready;
  assign out_load = (state == ST_DIV) && div_status.done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = div_start ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles.valid <= 1'b0;
    end else if (out_load) begin
      tiles.valid <= 1'b1;
    end else if (tiles.ready) begin
      tiles.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tiles.tile_row   <= TILE_IDX_W'(row_q);
      tiles.tile_col   <= TILE_IDX_W'(col_q);
      tiles.mean       <= div_mean;
      tiles.frame_done <= done_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mta_checker.sv =====
// Port-level checks for the mosaic tile average unit, attached by the bind at the end.
// Depends on mta_pkg and the top level's ports.
`default_nettype none

module mta_checker
  import mta_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [MEAN_W-1:0]     out_mean
);

  // A result that is not taken stays in place.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_mean))
    else $error("stalled result changed or dropped");

  // The step division keeps the input closed right after reset.
  assert property (@(posedge clk) $past(rst) |-> !in_ready)
    else $error("pixel input open right after reset");

  // Every pixel needs a read and a write back of its sum, so transfers never follow back to back.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted in consecutive cycles");

  // A write to frame_width or frame_height restarts the step division before any pixel is taken.
  assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) |=> !in_ready)
    else $error("pixel input open right after a register write");

endmodule

bind mosaic_tile_average_unit mta_checker u_mta_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (tiles.valid),
  .out_ready (tiles.ready),
  .out_mean  (tiles.mean)
);

`default_nettype wire

// ===== tb/mosaic_tile_average_unit_tb.sv =====
// Testbench for the mosaic tile average unit: streams raster pixels under random bursts and
// output stalls, predicts every tile mean in a scoreboard and checks the results in order.
// Depends on mta_pkg, the stream interfaces in mta_if and the unit's RTL.

module mosaic_tile_average_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mta_pkg::*;

  localparam int GRID_COLS        = 20;
  localparam int GRID_ROWS        = 20;
  localparam int NUM_ITEMS        = 1700;
  localparam int DRAIN_CYCLES     = 16;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS      = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [PIX_W-1:0] BIT_WALK [10] = '{0, 255, 1, 2, 4, 8, 16, 32, 64, 128};

  typedef struct packed {
    logic [TILE_IDX_W-1:0] row;
    logic [TILE_IDX_W-1:0] col;
    logic [MEAN_W-1:0]     mean;
    logic                  done;
  } tile_result_t;

  typedef enum {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_SPARSE} rx_mode_t;
  typedef enum {PIX_RANDOM, PIX_MAX, PIX_MIN, PIX_NARROW} pix_mode_t;

  class tile_mean_scoreboard;
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;
    int unsigned      step_x;
    int unsigned      step_y;
    int unsigned      col_pos;
    int unsigned      row_pos;
    longint unsigned  tile_sum [GRID_COLS];
    tile_result_t     expected_tiles [$];
    int unsigned      errors;

    function void restart_frame();
      step_x  = frame_w / GRID_COLS;
      step_y  = frame_h / GRID_ROWS;
      col_pos = 0;
      row_pos = 0;
      foreach (tile_sum[k]) tile_sum[k] = 0;
    endfunction

    function void reset_state();
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      errors  = 0;
      expected_tiles.delete();
      restart_frame();
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) begin
        frame_w = data;
      end else if (idx == REG_FRAME_HEIGHT) begin
        frame_h = data;
      end else begin
        return;
      end
      restart_frame();
    endfunction

    function int unsigned span(int unsigned idx, int unsigned count, int unsigned step);
      if (idx == count - 1) return (step == 0) ? 0 : step - 1;
      return step;
    endfunction

    function bit find_tile(input int unsigned pos, input int unsigned count,
                           input int unsigned step, output int unsigned idx);
      int unsigned t;
      idx = 0;
      if (step == 0) return 0;
      t = pos / step;
      if (t >= count) return 0;
      if (pos - t * step >= span(t, count, step)) return 0;
      idx = t;
      return 1;
    endfunction

    function int last_filled(int unsigned count, int unsigned step);
      if (step >= 2) return int'(count) - 1;
      if (step == 1) return int'(count) - 2;
      return -1;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned     tc;
      int unsigned     tr;
      int unsigned     w;
      int unsigned     h;
      longint unsigned quotient;
      tile_result_t    r;
      if (find_tile(col_pos, GRID_COLS, step_x, tc) &&
          find_tile(row_pos, GRID_ROWS, step_y, tr)) begin
        w = span(tc, GRID_COLS, step_x);
        h = span(tr, GRID_ROWS, step_y);
        tile_sum[tc] += pix;
        if (col_pos == tc * step_x + w - 1 && row_pos == tr * step_y + h - 1) begin
          quotient = tile_sum[tc] / (longint'(w) * longint'(h));
          r.row    = tr[TILE_IDX_W-1:0];
          r.col    = tc[TILE_IDX_W-1:0];
          r.mean   = quotient[MEAN_W-1:0];
          r.done   = (int'(tc) == last_filled(GRID_COLS, step_x)) &&
                     (int'(tr) == last_filled(GRID_ROWS, step_y));
          tile_sum[tc] = 0;
          expected_tiles.insert(expected_tiles.size(), r);
        end
      end
      col_pos++;
      if (col_pos >= frame_w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= frame_h) row_pos = 0;
      end
    endfunction

    function void check_tile(tile_result_t got);
      tile_result_t want;
      if (expected_tiles.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Unexpected tile: row %0d col %0d mean %0d done %0d",
                   got.row, got.col, got.mean, got.done);
        return;
      end
      want = expected_tiles.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Tile mismatch: expected r%0d c%0d m%0d d%0d, got r%0d c%0d m%0d d%0d",
                   want.row, want.col, want.mean, want.done,
                   got.row, got.col, got.mean, got.done);
      end
    endfunction

    function int unsigned pending();
      return expected_tiles.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    hold_req;
  int unsigned           sent;
  tile_result_t          seen_tile;

  tile_mean_scoreboard sb = new();

  mta_pixel_if pixels_if ();
  mta_tile_if  tiles_if ();

  mosaic_tile_average_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels_if),
    .tiles     (tiles_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PIX_W-1:0] pick_pixel(pix_mode_t mode);
    case (mode)
      PIX_MAX:    return 8'hFF;
      PIX_MIN:    return 8'h00;
      PIX_NARROW: return PIX_W'($urandom_range(100, 103));
      default:    return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] value);
    @(negedge clk);
    pixels_if.valid <= 1'b1;
    pixels_if.pixel <= value;
    @(posedge clk);
    while (!pixels_if.ready) @(posedge clk);
    sb.note_pixel(value);
    sent++;
  endtask

  task automatic pause_sending(input int unsigned cycles);
    @(negedge clk);
    pixels_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    pause_sending(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.apply_register(idx, data);
  endtask

  task automatic send_stream(input int unsigned count, input pix_mode_t mode);
    int unsigned burst;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        if (i != 0) pause_sending($urandom_range(1, 6));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      end
      push_pixel(pick_pixel(mode));
      burst--;
    end
  endtask

  task automatic random_phase();
    int unsigned kind;
    int unsigned w;
    int unsigned h;
    int unsigned count;
    pix_mode_t   mode;
    kind = $urandom_range(0, 9);
    if (kind <= 1) begin
      w = $urandom_range(0, 1) ? $urandom_range(0, 19) : $urandom_range(0, 4095);
      h = $urandom_range(0, 4095);
      count = $urandom_range(20, 40);
    end else if (kind <= 4) begin
      w = $urandom_range(20, 45);
      h = $urandom_range(20, 22);
      count = w * h + $urandom_range(0, 40);
    end else begin
      w = $urandom_range(20, 120);
      h = $urandom_range(20, 60);
      count = $urandom_range(60, 250);
    end
    if (count > NUM_ITEMS - sent) count = NUM_ITEMS - sent;
    mode = pix_mode_t'($urandom_range(0, 3));
    drain_results();
    if ($urandom_range(0, 4) == 0)
      write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                     CFG_DATA_W'($urandom_range(0, 4095)));
    write_register(REG_FRAME_WIDTH, w[DIM_W-1:0]);
    write_register(REG_FRAME_HEIGHT, h[DIM_W-1:0]);
    send_stream(count, mode);
  endtask

  initial begin
    cfg_we          = 1'b0;
    cfg_index       = REG_FRAME_WIDTH;
    cfg_data        = '0;
    pixels_if.valid = 1'b0;
    pixels_if.pixel = '0;
    hold_req        = 1'b0;
    sent            = 0;
    rst             = 1'b1;
    sb.reset_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h80);

    drain_results();
    write_register(REG_FRAME_WIDTH, 12'd20);
    write_register(REG_FRAME_HEIGHT, 12'd20);
    foreach (BIT_WALK[k]) push_pixel(BIT_WALK[k]);
    drain_results();
    write_register(REG_SPARE_2, 12'hFFF);
    write_register(REG_SPARE_3, 12'h000);
    push_pixel(8'd77);
    push_pixel(8'd200);

    drain_results();
    write_register(REG_FRAME_WIDTH, 12'd0);
    write_register(REG_FRAME_HEIGHT, 12'd0);
    repeat (3) push_pixel(PIX_W'($urandom_range(0, 255)));

    drain_results();
    write_register(REG_FRAME_WIDTH, 12'd19);
    write_register(REG_FRAME_HEIGHT, 12'hFFF);
    repeat (3) push_pixel(PIX_W'($urandom_range(0, 255)));

    drain_results();
    write_register(REG_FRAME_WIDTH, 12'hFFF);
    write_register(REG_FRAME_HEIGHT, 12'd40);
    repeat (3) push_pixel(PIX_W'($urandom_range(0, 255)));

    // One tile per pixel outside the last column and row, so a long output stall backs the block up into its input.
    drain_results();
    write_register(REG_FRAME_WIDTH, 12'd20);
    write_register(REG_FRAME_HEIGHT, 12'd20);
    hold_req = 1'b1;
    send_stream(200, PIX_RANDOM);
    drain_results();
    send_stream(200, PIX_RANDOM);

    while (sent < NUM_ITEMS) random_phase();

    drain_results();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    rx_mode_t    mode;
    int unsigned run;
    bit          held;
    tiles_if.ready = 1'b0;
    held = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      run  = $urandom_range(16, 128);
      repeat (run) begin
        @(negedge clk);
        if (hold_req && !held) begin
          held = 1'b1;
          tiles_if.ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          RX_OPEN:       tiles_if.ready <= 1'b1;
          RX_COIN:       tiles_if.ready <= 1'($urandom_range(0, 1));
          RX_RARE_STALL: tiles_if.ready <= ($urandom_range(0, 7) != 0);
          default:       tiles_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && tiles_if.valid && tiles_if.ready) begin
      seen_tile = {tiles_if.tile_row, tiles_if.tile_col, tiles_if.mean, tiles_if.frame_done};
      sb.check_tile(seen_tile);
    end
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
